/* rtl/fmst_pkg.sv */
`timescale 1ns / 1ps

package fmst_pkg;

	// Cluster geometry limits
	localparam int MAX_SLOTS = 512;
	localparam int MAX_DIM   = 20;

	// Field widths
	localparam int SEQ_W      = 16;
	localparam int PT_W       = 7;
	localparam int DIM_W      = 5;
	localparam int REQ_W      = 2;
	localparam int OUT_SLOT_W = 9;
	localparam int MISS_W     = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Slot map organization: words of WORD_W bits in a small RAM
	localparam int WORD_W  = 32;
	localparam int WB      = $clog2(WORD_W);
	localparam int WORDS   = MAX_SLOTS / WORD_W;
	localparam int ADDR_W  = $clog2(WORDS);
	localparam int SLOT_W  = $clog2(MAX_SLOTS);
	localparam int SCAN_W  = SLOT_W + 1;
	localparam int CNT_W   = $clog2(MAX_DIM * MAX_DIM + 1);
	localparam int LEN_W   = DIM_W + 1;
	localparam int LANE_W  = DIM_W + LEN_W;
	localparam int PROD_W  = 2 * DIM_W;
	// Widest slot: quotient times row length plus column count
	localparam int SLOT_FULL_W = SEQ_W + LEN_W;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_SEQ = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_FEC  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_FEC  = 3'd4;

	// Divider request and response
	typedef struct packed {
		logic             start;
		logic [SEQ_W-1:0] dividend;
		logic [DIM_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SEQ_W-1:0] quotient;
	} div_rsp_t;

	// Saturate a dimension to 1..MAX_DIM
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(MAX_DIM))
			r = DIM_W'(MAX_DIM);
		else
			r = v;
		return r;
	endfunction

endpackage

/* rtl/fmst_ram.sv */
`timescale 1ns / 1ps

module fmst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

/* rtl/fmst_div.sv */
`timescale 1ns / 1ps

module fmst_div (
	input  logic              clk,
	input  logic              arst_n,
	input  fmst_pkg::div_req_t req,
	output fmst_pkg::div_rsp_t rsp
);
	import fmst_pkg::*;

	localparam int STEP_W = $clog2(SEQ_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIM_W-1:0]  rem_q;
	logic [DIM_W-1:0]  dsr_q;
	logic [SEQ_W-1:0]  quo_q;

	logic [DIM_W:0]    trial;
	logic              fits;

	// One restoring step: bring down the next dividend bit
	always_comb begin
		trial = {rem_q, quo_q[SEQ_W-1]};
		fits  = trial >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				rem_q  <= '0;
				dsr_q  <= req.divisor;
				quo_q  <= req.dividend;
			end else if (busy_q) begin
				// Shift one quotient bit in per cycle
				rem_q <= fits ? DIM_W'(trial - {1'b0, dsr_q}) : trial[DIM_W-1:0];
				quo_q <= {quo_q[SEQ_W-2:0], fits};
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(SEQ_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

/* rtl/fec_matrix_slot_tracker_top.sv */
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// input     in_valid / in_ready  req_type, payload_type, seq_num, fec_base
// output    out_valid / out_ready slot_index, out_of_range, in_cluster,
//                                missing_count, all_present, none_present
// config    cfg_we               cfg_index, cfg_data
//
// A query or clear goes from the start state straight to done; an insert adds
// a bit-serial divide by the column count (16 steps), then slot, check and
// read-modify-write of one map word, skipped for an out-of-range slot.
// After a write to rows or columns the next item first recounts present media
// slots, one 32-slot word at a time, over rows*(columns+1) slots. Reset clears
// the per-word valid flags at once, so no clearing pass is needed. in_ready is
// high only between items; a result waiting on out_ready holds the sequencer.

module fec_matrix_slot_tracker_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [fmst_pkg::REQ_W-1:0]          req_type,
	input  logic [fmst_pkg::PT_W-1:0]           payload_type,
	input  logic [fmst_pkg::SEQ_W-1:0]          seq_num,
	input  logic [fmst_pkg::SEQ_W-1:0]          fec_base,
	// output channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [fmst_pkg::OUT_SLOT_W-1:0]     slot_index,
	output logic                                out_of_range,
	output logic                                in_cluster,
	output logic [fmst_pkg::MISS_W-1:0]         missing_count,
	output logic                                all_present,
	output logic                                none_present,
	// configuration
	input  logic                                cfg_we,
	input  logic [fmst_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fmst_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import fmst_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_LD,
		S_SCAN_BIT,
		S_START,
		S_DIV,
		S_SLOT,
		S_CHECK,
		S_UPDATE,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		KIND_ROW,
		KIND_COL,
		KIND_MEDIA
	} kind_t;

	// Configuration registers
	logic [SEQ_W-1:0] base_q;
	logic [DIM_W-1:0] rows_q;
	logic [DIM_W-1:0] cols_q;
	logic [PT_W-1:0]  col_fec_q;
	logic [PT_W-1:0]  row_fec_q;

	// Sequencer state
	state_t             state_q;
	kind_t              kind_q;
	logic               dirty_q;
	logic [REQ_W-1:0]   req_q;
	logic [PT_W-1:0]    pt_q;
	logic [SEQ_W-1:0]   seq_q;
	logic [SEQ_W-1:0]   fb_q;
	logic [SEQ_W-1:0]   d_q;
	logic [SLOT_FULL_W-1:0] slot_q;
	logic               oor_q;
	logic [CNT_W-1:0]   media_cnt_q;
	logic [WORDS-1:0]   row_vld_q;
	logic [SCAN_W-1:0]  scan_s_q;
	logic [DIM_W-1:0]   col_q;
	logic [WORD_W-1:0]  word_q;

	// Output registers
	logic                  out_valid_q;
	logic [OUT_SLOT_W-1:0] slot_index_q;
	logic                  oor_out_q;
	logic                  in_cluster_q;
	logic [MISS_W-1:0]     missing_q;
	logic                  all_q;
	logic                  none_q;

	// Geometry
	logic [DIM_W-1:0]  r_dim;
	logic [DIM_W-1:0]  c_dim;
	logic [LEN_W-1:0]  row_len;
	logic [PROD_W-1:0] media_prod;
	logic [CNT_W-1:0]  media_total;
	logic [LANE_W-1:0] lane_prod;
	logic [LANE_W-1:0] slot_total;
	logic [SCAN_W-1:0] scan_lim;

	// Datapath
	logic              is_row;
	logic              is_col;
	logic [SEQ_W-1:0]  d_val;
	logic [SLOT_FULL_W-1:0] slot_val;
	logic              slot_oor;
	logic [ADDR_W-1:0] slot_addr;
	logic [WB-1:0]     slot_bit;
	logic [ADDR_W-1:0] scan_addr;
	logic [WORD_W-1:0] cur_word;
	logic              old_bit;
	logic              media_hit;
	logic [SEQ_W-1:0]  probe;

	// RAM and divider connections
	logic              ram_we;
	logic [ADDR_W-1:0] ram_raddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			rows_q    <= DIM_W'(4);
			cols_q    <= DIM_W'(4);
			col_fec_q <= PT_W'(96);
			row_fec_q <= PT_W'(97);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BASE_SEQ: base_q    <= cfg_data[SEQ_W-1:0];
				CFG_ROWS:     rows_q    <= cfg_data[DIM_W-1:0];
				CFG_COLUMNS:  cols_q    <= cfg_data[DIM_W-1:0];
				CFG_COL_FEC:  col_fec_q <= cfg_data[PT_W-1:0];
				CFG_ROW_FEC:  row_fec_q <= cfg_data[PT_W-1:0];
				default: ;
			endcase
		end
	end

	// Derive cluster geometry
	always_comb begin
		r_dim       = clamp_dim(rows_q);
		c_dim       = clamp_dim(cols_q);
		row_len     = LEN_W'(c_dim) + LEN_W'(1);
		media_prod  = PROD_W'(r_dim) * PROD_W'(c_dim);
		media_total = CNT_W'(media_prod);
		lane_prod   = LANE_W'(r_dim) * LANE_W'(row_len);
		slot_total  = lane_prod + LANE_W'(c_dim);
		if (lane_prod > LANE_W'(MAX_SLOTS))
			scan_lim = SCAN_W'(MAX_SLOTS);
		else
			scan_lim = SCAN_W'(lane_prod);
	end

	// Classify packet and form offsets and slot
	always_comb begin
		is_row = pt_q == row_fec_q;
		is_col = !is_row && (pt_q == col_fec_q);
		d_val  = ((is_row || is_col) ? fb_q : seq_q) - base_q;
		unique case (kind_q)
			KIND_ROW:
				slot_val = SLOT_FULL_W'(div_rsp.quotient) * SLOT_FULL_W'(row_len)
					+ SLOT_FULL_W'(c_dim);
			KIND_COL:
				slot_val = SLOT_FULL_W'(d_q) + SLOT_FULL_W'(lane_prod);
			default:
				slot_val = SLOT_FULL_W'(d_q) + SLOT_FULL_W'(div_rsp.quotient);
		endcase
		slot_oor  = (slot_q >= SLOT_FULL_W'(slot_total))
			|| (slot_q >= SLOT_FULL_W'(MAX_SLOTS));
		slot_addr = slot_q[SLOT_W-1:WB];
		slot_bit  = slot_q[WB-1:0];
		scan_addr = scan_s_q[SLOT_W-1:WB];
		cur_word  = row_vld_q[slot_addr] ? ram_rdata : '0;
		old_bit   = cur_word[slot_bit];
		media_hit = (kind_q == KIND_MEDIA) && (d_q < SEQ_W'(media_total));
		probe     = seq_q - base_q;
	end

	// Drive map RAM and divider
	always_comb begin
		ram_we           = state_q == S_UPDATE;
		ram_raddr        = (state_q == S_SCAN_RD) ? scan_addr : slot_addr;
		ram_wdata        = cur_word | (WORD_W'(1) << slot_bit);
		div_req.start    = (state_q == S_START) && (req_q == REQ_INSERT);
		div_req.dividend = d_val;
		div_req.divisor  = c_dim;
	end

	fmst_ram #(
		.WIDTH(WORD_W),
		.DEPTH(WORDS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_addr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	fmst_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kind_q       <= KIND_MEDIA;
			dirty_q      <= 1'b0;
			req_q        <= '0;
			pt_q         <= '0;
			seq_q        <= '0;
			fb_q         <= '0;
			d_q          <= '0;
			slot_q       <= '0;
			oor_q        <= 1'b0;
			media_cnt_q  <= '0;
			row_vld_q    <= '0;
			scan_s_q     <= '0;
			col_q        <= '0;
			word_q       <= '0;
			out_valid_q  <= 1'b0;
			slot_index_q <= '0;
			oor_out_q    <= 1'b0;
			in_cluster_q <= 1'b0;
			missing_q    <= '0;
			all_q        <= 1'b0;
			none_q       <= 1'b0;
		end else begin
			// Retire an output transfer unless a new result replaces it
			if (out_valid_q && out_ready && state_q != S_DONE)
				out_valid_q <= 1'b0;
			// Mark the media count stale on a geometry change
			if (cfg_we && (cfg_index == CFG_ROWS || cfg_index == CFG_COLUMNS))
				dirty_q <= 1'b1;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q <= req_type;
						pt_q  <= payload_type;
						seq_q <= seq_num;
						fb_q  <= fec_base;
						if (dirty_q) begin
							scan_s_q    <= '0;
							col_q       <= '0;
							media_cnt_q <= '0;
							state_q     <= S_SCAN_RD;
						end else begin
							state_q <= S_START;
						end
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_LD;
				S_SCAN_LD: begin
					word_q  <= row_vld_q[scan_addr] ? ram_rdata : '0;
					state_q <= S_SCAN_BIT;
				end
				S_SCAN_BIT: begin
					// Count one slot, skipping row-FEC positions
					if (word_q[0] && col_q != c_dim)
						media_cnt_q <= media_cnt_q + CNT_W'(1);
					word_q   <= word_q >> 1;
					col_q    <= (col_q == c_dim) ? '0 : col_q + DIM_W'(1);
					scan_s_q <= scan_s_q + SCAN_W'(1);
					if (scan_s_q + SCAN_W'(1) == scan_lim) begin
						dirty_q <= 1'b0;
						state_q <= S_START;
					end else if (scan_s_q[WB-1:0] == '1) begin
						state_q <= S_SCAN_RD;
					end
				end
				S_START: begin
					slot_q <= '0;
					oor_q  <= 1'b0;
					d_q    <= d_val;
					kind_q <= is_row ? KIND_ROW : (is_col ? KIND_COL : KIND_MEDIA);
					unique case (req_q)
						REQ_INSERT: state_q <= S_DIV;
						REQ_CLEAR: begin
							row_vld_q   <= '0;
							media_cnt_q <= '0;
							state_q     <= S_DONE;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_DIV: begin
					if (div_rsp.done)
						state_q <= S_SLOT;
				end
				S_SLOT: begin
					slot_q  <= slot_val;
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					oor_q   <= slot_oor;
					state_q <= slot_oor ? S_DONE : S_UPDATE;
				end
				S_UPDATE: begin
					// Set the slot bit; count a newly present media slot
					row_vld_q[slot_addr] <= 1'b1;
					if (!old_bit && media_hit)
						media_cnt_q <= media_cnt_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						slot_index_q <= slot_q[OUT_SLOT_W-1:0];
						oor_out_q    <= oor_q;
						in_cluster_q <= probe < SEQ_W'(media_total);
						missing_q    <= MISS_W'(media_total - media_cnt_q);
						all_q        <= media_cnt_q == media_total;
						none_q       <= media_cnt_q == '0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready      = state_q == S_IDLE;
	assign out_valid     = out_valid_q;
	assign slot_index    = slot_index_q;
	assign out_of_range  = oor_out_q;
	assign in_cluster    = in_cluster_q;
	assign missing_count = missing_q;
	assign all_present   = all_q;
	assign none_present  = none_q;

`ifndef SYNTH
	// A clean count never exceeds the media slots of the geometry
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !dirty_q) |-> (media_cnt_q <= media_total))
		else $error("media count above media total");

	// The divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV))
		else $error("divider done outside divide state");

	// The map is written only for an in-range slot
	a_map_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (!oor_q && slot_q < SLOT_FULL_W'(MAX_SLOTS)))
		else $error("map write for out-of-range slot");
`endif

endmodule

/* tb/tb_fec_matrix_slot_tracker_top.sv */
`timescale 1ns / 1ps

module tb_fec_matrix_slot_tracker_top;
	import fmst_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 100;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic [PT_W-1:0]  pt;
		logic [SEQ_W-1:0] seq;
		logic [SEQ_W-1:0] fb;
	} request_t;

	typedef struct packed {
		logic [OUT_SLOT_W-1:0] slot;
		logic                  oor;
		logic                  inc;
		logic [MISS_W-1:0]     missing;
		logic                  all_p;
		logic                  none_p;
	} status_t;

	// Cluster map predictor plus the queue of statuses still owed by the block
	class cluster_status_sb;
		logic [SEQ_W-1:0] base_seq;
		logic [DIM_W-1:0] rows_reg;
		logic [DIM_W-1:0] cols_reg;
		logic [PT_W-1:0]  col_fec_pt;
		logic [PT_W-1:0]  row_fec_pt;
		bit               slot_map [MAX_SLOTS];
		status_t          status_q [$];
		int               errors;

		function new();
			base_seq   = '0;
			rows_reg   = 5'd4;
			cols_reg   = 5'd4;
			col_fec_pt = 7'd96;
			row_fec_pt = 7'd97;
			foreach (slot_map[i]) slot_map[i] = 1'b0;
			errors = 0;
		endfunction

		// Saturate a dimension into 1..MAX_DIM
		function int unsigned sat_dim(logic [DIM_W-1:0] v);
			if (v == '0) return 1;
			if (v > MAX_DIM) return MAX_DIM;
			return v;
		endfunction

		function int unsigned used_rows();
			return sat_dim(rows_reg);
		endfunction

		function int unsigned used_cols();
			return sat_dim(cols_reg);
		endfunction

		function int pending();
			return status_q.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_BASE_SEQ: base_seq = data;
				CFG_ROWS:     rows_reg = data[DIM_W-1:0];
				CFG_COLUMNS:  cols_reg = data[DIM_W-1:0];
				CFG_COL_FEC:  col_fec_pt = data[PT_W-1:0];
				CFG_ROW_FEC:  row_fec_pt = data[PT_W-1:0];
				default: ;
			endcase
		endfunction

		// Apply one accepted request to the map and queue the status it owes
		function void note_request(request_t rq);
			int unsigned r, c, media_total, slot_total, slot, n, s;
			logic [SEQ_W-1:0] d;
			status_t st;
			r = used_rows();
			c = used_cols();
			media_total = r * c;
			slot_total = (r + 1) * (c + 1) - 1;
			slot = 0;
			st = '0;
			if (rq.req == REQ_CLEAR) begin
				foreach (slot_map[i]) slot_map[i] = 1'b0;
			end else if (rq.req == REQ_INSERT) begin
				// row FEC wins when both FEC types match
				if (rq.pt == row_fec_pt) begin
					d = rq.fb - base_seq;
					slot = d / c * (c + 1) + c;
				end else if (rq.pt == col_fec_pt) begin
					d = rq.fb - base_seq;
					slot = d + r * (c + 1);
				end else begin
					d = rq.seq - base_seq;
					slot = d + d / c;
				end
				if (slot >= slot_total || slot >= MAX_SLOTS)
					st.oor = 1'b1;
				else
					slot_map[slot] = 1'b1;
			end
			// count present media slots of the current geometry
			n = 0;
			for (int unsigned i = 0; i < media_total; i++) begin
				s = i + i / c;
				if (s < MAX_SLOTS && slot_map[s]) n++;
			end
			d = rq.seq - base_seq;
			st.slot    = OUT_SLOT_W'(slot);
			st.inc     = (d < media_total);
			st.missing = MISS_W'(media_total - n);
			st.all_p   = (n == media_total);
			st.none_p  = (n == 0);
			status_q.push_back(st);
		endfunction

		// Compare one transferred status with the oldest one owed
		function void check_status(status_t got);
			status_t want;
			if (status_q.size() == 0) begin
				$error("status transfer with no request outstanding: slot_index %0d", got.slot);
				errors++;
				return;
			end
			want = status_q.pop_front();
			if (got.slot !== want.slot) begin
				$error("slot_index: expected %0d, actual %0d", want.slot, got.slot);
				errors++;
			end
			if (got.oor !== want.oor) begin
				$error("out_of_range: expected %0d, actual %0d", want.oor, got.oor);
				errors++;
			end
			if (got.inc !== want.inc) begin
				$error("in_cluster: expected %0d, actual %0d", want.inc, got.inc);
				errors++;
			end
			if (got.missing !== want.missing) begin
				$error("missing_count: expected %0d, actual %0d", want.missing, got.missing);
				errors++;
			end
			if (got.all_p !== want.all_p) begin
				$error("all_present: expected %0d, actual %0d", want.all_p, got.all_p);
				errors++;
			end
			if (got.none_p !== want.none_p) begin
				$error("none_present: expected %0d, actual %0d", want.none_p, got.none_p);
				errors++;
			end
		endfunction

		function void report_leftover();
			if (status_q.size() != 0) begin
				$error("%0d statuses never arrived", status_q.size());
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [REQ_W-1:0]      req_type;
	logic [PT_W-1:0]       payload_type;
	logic [SEQ_W-1:0]      seq_num;
	logic [SEQ_W-1:0]      fec_base;
	logic                  out_valid;
	logic                  out_ready;
	logic [OUT_SLOT_W-1:0] slot_index;
	logic                  out_of_range;
	logic                  in_cluster;
	logic [MISS_W-1:0]     missing_count;
	logic                  all_present;
	logic                  none_present;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cluster_status_sb sb;
	bit               no_idle;
	int unsigned      cycle_count;

	fec_matrix_slot_tracker_top dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Abort a hung run
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("fec_matrix_slot_tracker_top regression: fail");
			$finish;
		end
	end

	function automatic int unsigned draw_gap();
		if (no_idle) return 0;
		return $urandom_range(18, 0);
	endfunction

	// Pick a payload type that neither FEC type claims
	function automatic logic [PT_W-1:0] media_pt();
		logic [PT_W-1:0] p;
		p = $urandom;
		while (p == sb.row_fec_pt || p == sb.col_fec_pt) p = $urandom;
		return p;
	endfunction

	// Hold valid and payload until the transfer, then note the request
	task automatic send_request(input request_t rq);
		int unsigned gap;
		gap = draw_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= rq.req;
		payload_type <= rq.pt;
		seq_num      <= rq.seq;
		fec_base     <= rq.fb;
		do @(posedge clk); while (!(in_valid && in_ready));
		sb.note_request(rq);
	endtask

	task automatic send(input logic [REQ_W-1:0] req, input logic [PT_W-1:0] pt,
			input logic [SEQ_W-1:0] seq, input logic [SEQ_W-1:0] fb);
		request_t rq;
		rq = '{req: req, pt: pt, seq: seq, fb: fb};
		send_request(rq);
	endtask

	// Stop sending and wait for every owed status
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly well-formed inserts aimed at the cluster, some noise, queries, unused codes and clears
	function automatic request_t make_random_request();
		request_t rq;
		int unsigned pick, c, total;
		c = sb.used_cols();
		total = sb.used_rows() * c;
		rq.req = REQ_INSERT;
		rq.pt  = $urandom;
		rq.seq = $urandom;
		rq.fb  = $urandom;
		pick = $urandom_range(99, 0);
		if (pick < 4) begin
			rq.req = REQ_CLEAR;
		end else if (pick < 12) begin
			rq.req = $urandom_range(1, 0) ? REQ_QUERY : REQ_UNUSED;
			if (pick < 9) rq.seq = SEQ_W'(sb.base_seq + $urandom_range(total, 0));
		end else if (pick < 22) begin
			// raw noise insert
		end else if (pick < 74) begin
			rq.pt  = media_pt();
			rq.seq = SEQ_W'(sb.base_seq + $urandom_range(total - 1, 0));
		end else if (pick < 87) begin
			rq.pt = sb.row_fec_pt;
			rq.fb = SEQ_W'(sb.base_seq + $urandom_range(total + c - 1, 0));
		end else begin
			rq.pt = sb.col_fec_pt;
			rq.fb = SEQ_W'(sb.base_seq + $urandom_range(c, 0));
		end
		return rq;
	endfunction

	// One setting of all registers, then a burst of traffic
	task automatic run_phase(input logic [SEQ_W-1:0] b, input logic [DIM_W-1:0] r,
			input logic [DIM_W-1:0] c, input logic [PT_W-1:0] cp, input logic [PT_W-1:0] rp,
			input bit fill);
		drain();
		program_reg(CFG_BASE_SEQ, b);
		program_reg(CFG_ROWS, CFG_DATA_W'(r));
		program_reg(CFG_COLUMNS, CFG_DATA_W'(c));
		program_reg(CFG_COL_FEC, CFG_DATA_W'(cp));
		program_reg(CFG_ROW_FEC, CFG_DATA_W'(rp));
		no_idle = $urandom_range(1, 0);
		// keep stale bits across a geometry change half the time
		if ($urandom_range(1, 0)) send(REQ_CLEAR, $urandom, $urandom, $urandom);
		if (fill)
			for (int i = 0; i < sb.used_rows() * sb.used_cols(); i++)
				send(REQ_INSERT, media_pt(), SEQ_W'(b + i), $urandom);
		for (int k = 0; k < PHASE_ITEMS; k++) begin
			if ($urandom_range(29, 0) == 0) no_idle = !no_idle;
			if ($urandom_range(49, 0) == 0) drain();
			send_request(make_random_request());
		end
	endtask

	// Edge slots and odd requests under the reset geometry of 4 x 4
	task automatic directed_part();
		send(REQ_QUERY, 7'd0, 16'd0, 16'd0);
		send(REQ_INSERT, 7'd0, 16'd0, 16'd0);
		send(REQ_INSERT, 7'd127, 16'd15, 16'hFFFF);
		send(REQ_INSERT, 7'd97, 16'd0, 16'd0);
		send(REQ_INSERT, 7'd97, 16'd0, 16'd12);
		send(REQ_INSERT, 7'd96, 16'd0, 16'd0);
		send(REQ_INSERT, 7'd96, 16'hFFFF, 16'd3);
		send(REQ_INSERT, 7'd96, 16'd0, 16'd4);
		send(REQ_INSERT, 7'd97, 16'd0, 16'd16);
		send(REQ_INSERT, 7'd1, 16'hFFFF, 16'd0);
		send(REQ_INSERT, 7'd97, 16'd0, 16'hFFFF);
		send(REQ_INSERT, 7'h55, 16'hAAAA, 16'h5555);
		send(REQ_INSERT, 7'h2A, 16'h5555, 16'hAAAA);
		send(REQ_INSERT, 7'd0, 16'd0, 16'd0);
		send(REQ_UNUSED, 7'd0, 16'hFFFF, 16'd0);
		send(REQ_CLEAR, 7'd127, 16'hFFFF, 16'hFFFF);
		send(REQ_INSERT, 7'd3, 16'd7, 16'd0);
		send(REQ_QUERY, 7'd0, 16'd16, 16'd0);
		// both FEC types equal: row interpretation takes the packet
		drain();
		program_reg(CFG_COL_FEC, CFG_DATA_W'(33));
		program_reg(CFG_ROW_FEC, CFG_DATA_W'(33));
		send(REQ_INSERT, 7'd33, 16'd0, 16'd5);
		send(REQ_INSERT, 7'd96, 16'd9, 16'd0);
	endtask

	// Receive side: check each status transfer, then stall at random
	initial begin
		int unsigned hold;
		status_t got;
		hold = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.slot    = slot_index;
				got.oor     = out_of_range;
				got.inc     = in_cluster;
				got.missing = missing_count;
				got.all_p   = all_present;
				got.none_p  = none_present;
				sb.check_status(got);
				hold = draw_gap();
				if (hold != 0) out_ready <= 1'b0;
			end else if (!out_ready) begin
				if (hold > 1) begin
					hold--;
				end else begin
					hold = 0;
					out_ready <= 1'b1;
				end
			end
		end
	end

	initial begin
		sb = new();
		no_idle      = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		req_type     = '0;
		payload_type = '0;
		seq_num      = '0;
		fec_base     = '0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_part();

		run_phase(16'h0000, 5'd4, 5'd4, 7'd96, 7'd97, 1'b0);
		run_phase(16'hFFF0, 5'd1, 5'd1, 7'd0, 7'd127, 1'b0);
		run_phase(16'h8000, 5'd20, 5'd20, 7'd127, 7'd0, 1'b1);
		run_phase($urandom, 5'd0, 5'd0, $urandom, $urandom, 1'b0);
		run_phase($urandom, 5'd31, 5'd31, 7'd42, 7'd42, 1'b0);
		run_phase(16'hFFFF, 5'd20, 5'd1, $urandom, $urandom, 1'b0);
		run_phase($urandom, 5'd1, 5'd20, $urandom, $urandom, 1'b0);
		run_phase($urandom, 5'd2, 5'd3, $urandom, $urandom, 1'b0);
		for (int p = 0; p < 4; p++)
			run_phase($urandom, $urandom_range(31, 0), $urandom_range(31, 0),
				$urandom, $urandom, 1'b0);

		drain();
		repeat (40) @(posedge clk);
		sb.report_leftover();
		if (sb.errors == 0)
			$display("fec_matrix_slot_tracker_top regression: pass");
		else
			$display("fec_matrix_slot_tracker_top regression: fail");
		$finish;
	end

endmodule
